// ----- hw/rtl/bmfe_pkg.sv -----
// Shared types, widths and constants for the bell magnet field evaluator.
// Holds the exponential table entry function used at elaboration.
// No dependencies.
`timescale 1ns / 1ps

package bmfe_pkg;

    localparam int POS_W   = 23;
    localparam int PEAK_W  = 24;
    localparam int TUBE_W  = 22;
    localparam int MODE_W  = 2;
    localparam int FIELD_W = 24;
    localparam int CFGD_W  = 24;
    localparam int DZ_W    = 24;
    localparam int Q_W     = 24;
    localparam int DM_W    = 25;
    localparam int DML_W   = 20;
    localparam int ENT_W   = 17;
    localparam int MUL_W   = 28;
    localparam int NUM_W   = 53;
    localparam int DEN_W   = 42;
    localparam int QUO_W   = 25;

    localparam logic [22:0] BOX_X_LIMIT  = 23'd69120;
    localparam logic [22:0] BOX_Y_MARGIN = 23'd5120;
    localparam logic [23:0] GAUSS_END_DZ = 24'd97280;
    localparam logic [23:0] CUBIC_END_DZ = 24'd304640;
    localparam logic [31:0] RECIP_Q      = 32'd2617884828;
    localparam logic [27:0] RECIP_DM     = 28'd171798691;
    localparam logic [31:0] DIV_Q        = 32'd105;
    localparam logic [31:0] DIV_DM       = 32'd25;
    localparam logic [24:0] GAUSS_MU     = 25'd2981;
    localparam logic [14:0] GAUSS_K      = 15'd26166;
    localparam logic [18:0] CUBIC_C3     = 19'd275651;
    localparam logic signed [24:0] CUBIC_C2 = 25'sd7349441;
    localparam logic signed [29:0] CUBIC_C1 = 30'sd66048007;
    localparam logic signed [35:0] CUBIC_C0 = 36'sd209723253;
    localparam logic [DEN_W-1:0] NORM_Q30 = 42'd154200063;
    localparam logic [DEN_W-1:0] UNIT_Q16 = 42'd65536;

    localparam logic [MODE_W-1:0] MODE_BELL = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FIT  = 2'd2;

    typedef enum logic [1:0] {
        CFG_PEAK   = 2'd0,
        CFG_MIDDLE = 2'd1,
        CFG_MODE   = 2'd2,
        CFG_TUBE   = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_BELL  = 2'd1,
        KIND_GAUSS = 2'd2,
        KIND_CUBIC = 2'd3
    } t_kind;

    typedef struct packed {
        logic signed [PEAK_W-1:0] peak;
        logic signed [POS_W-1:0]  middle;
        logic [MODE_W-1:0]        mode;
        logic [TUBE_W-1:0]        tube;
    } t_cfg;

    typedef struct packed {
        logic            vld;
        t_kind           kind;
        logic [Q_W-1:0]  q;
        logic [DM_W-1:0] dm;
    } t_dist;

    typedef struct packed {
        logic             vld;
        t_kind            kind;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
        logic             neg;
    } t_quot;

    typedef struct packed {
        logic             vld;
        t_kind            kind;
        logic [QUO_W-1:0] quo;
        logic             neg;
    } t_dres;

    function automatic logic [ENT_W-1:0] exp_entry(input logic [63:0] x);
        logic [63:0]        term;
        logic [63:0]        prod;
        logic signed [63:0] sum;
        term = 64'd1 << 30;
        sum  = $signed(term);
        for (int k = 1; k <= 30; k++) begin
            prod = (term * x) >> 30;
            term = prod / 64'(k);
            if ((k & 1) == 1) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        if (sum < 0) begin
            sum = '0;
        end
        return ENT_W'(($unsigned(sum) + 64'd8192) >> 14);
    endfunction

endpackage

// ----- hw/rtl/bmfe_dist.sv -----
// Front stages: axial distance, box test, profile selection and the two
// constant-divisor scalings of the distance. Depends on bmfe_pkg.
`timescale 1ns / 1ps

module bmfe_dist (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_vld,
    input  logic signed [bmfe_pkg::POS_W-1:0]    i_pos_x,
    input  logic signed [bmfe_pkg::POS_W-1:0]    i_pos_y,
    input  logic signed [bmfe_pkg::POS_W-1:0]    i_pos_z,
    input  bmfe_pkg::t_cfg                       i_cfg,
    output bmfe_pkg::t_dist                      o_dist
);

    logic signed [23:0] w_dzs;
    logic [23:0]        w_dz;
    logic [22:0]        w_ax;
    logic [22:0]        w_ay;
    logic [22:0]        w_ylim;
    logic               w_inside;
    bmfe_pkg::t_kind    w_kind;

    logic               r_a_vld;
    bmfe_pkg::t_kind    r_a_kind;
    logic [23:0]        r_a_dz;

    logic [62:0]        w_p1;
    logic [57:0]        w_p2;
    logic               r_b_vld;
    bmfe_pkg::t_kind    r_b_kind;
    logic [23:0]        r_b_dz;
    logic [24:0]        r_b_q0;
    logic [25:0]        r_b_dm0;

    logic [31:0]        w_r1;
    logic [31:0]        w_r2;
    bmfe_pkg::t_dist    r_out;

    always_comb begin
        w_dzs    = {i_pos_z[22], i_pos_z} - {i_cfg.middle[22], i_cfg.middle};
        w_dz     = w_dzs[23] ? 24'(-w_dzs) : 24'(w_dzs);
        w_ax     = i_pos_x[22] ? 23'(-i_pos_x) : 23'(i_pos_x);
        w_ay     = i_pos_y[22] ? 23'(-i_pos_y) : 23'(i_pos_y);
        w_ylim   = {1'b0, i_cfg.tube} + bmfe_pkg::BOX_Y_MARGIN;
        w_inside = (w_ax < bmfe_pkg::BOX_X_LIMIT) && (w_ay < w_ylim);
        if (i_cfg.mode == bmfe_pkg::MODE_BELL) begin
            w_kind = bmfe_pkg::KIND_BELL;
        end else if (i_cfg.mode == bmfe_pkg::MODE_FIT && w_inside
                     && w_dz < bmfe_pkg::GAUSS_END_DZ) begin
            w_kind = bmfe_pkg::KIND_GAUSS;
        end else if (i_cfg.mode == bmfe_pkg::MODE_FIT && w_inside
                     && w_dz < bmfe_pkg::CUBIC_END_DZ) begin
            w_kind = bmfe_pkg::KIND_CUBIC;
        end else begin
            w_kind = bmfe_pkg::KIND_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= i_vld;
        end
        r_a_kind <= w_kind;
        r_a_dz   <= w_dz;
    end

    assign w_p1 = 63'({r_a_dz, 7'b0}) * 63'(bmfe_pkg::RECIP_Q);
    assign w_p2 = 58'({r_a_dz, 6'b0}) * 58'(bmfe_pkg::RECIP_DM);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else begin
            r_b_vld <= r_a_vld;
        end
        r_b_kind <= r_a_kind;
        r_b_dz   <= r_a_dz;
        r_b_q0   <= w_p1[62:38];
        r_b_dm0  <= w_p2[57:32];
    end

    assign w_r1 = 32'({r_b_dz, 7'b0}) - 32'(r_b_q0) * bmfe_pkg::DIV_Q;
    assign w_r2 = 32'({r_b_dz, 6'b0}) - 32'(r_b_dm0) * bmfe_pkg::DIV_DM;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.vld <= 1'b0;
        end else begin
            r_out.vld <= r_b_vld;
        end
        r_out.kind <= r_b_kind;
        r_out.q    <= 24'(r_b_q0 + 25'(w_r1 >= bmfe_pkg::DIV_Q));
        r_out.dm   <= 25'(r_b_dm0 + 26'(w_r2 >= bmfe_pkg::DIV_DM));
    end

    assign o_dist = r_out;

endmodule

// ----- hw/rtl/bmfe_shape.sv -----
// Profile stages: bell power chain, Gaussian exponent and table lookup,
// cubic Horner chain, and the scaled numerator and divisor. Uses bmfe_pkg.
`timescale 1ns / 1ps

module bmfe_shape #(
    parameter int EXP_TABLE_DEPTH = 256
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  bmfe_pkg::t_dist  i_dist,
    input  bmfe_pkg::t_cfg   i_cfg,
    output bmfe_pkg::t_quot  o_quot
);

    localparam int IW = $clog2(EXP_TABLE_DEPTH);
    localparam int AW = 18 + IW + 1;

    logic [bmfe_pkg::ENT_W-1:0] w_tab [EXP_TABLE_DEPTH];

    for (genvar gi = 0; gi < EXP_TABLE_DEPTH; gi++) begin : g_tab
        localparam logic [63:0] XQ = (64'(gi) << 31) / 64'(EXP_TABLE_DEPTH);
        assign w_tab[gi] = bmfe_pkg::exp_entry(XQ);
    end

    logic [47:0]        w_qq;
    logic [24:0]        w_e;
    logic               r3_vld;
    bmfe_pkg::t_kind    r3_kind;
    logic [24:0]        r3_u2;
    logic [39:0]        r3_es;
    logic [38:0]        r3_t1p;
    logic [19:0]        r3_dm;

    logic [49:0]        w_u2sq;
    logic [40:0]        w_es;
    logic [23:0]        w_t1;
    logic               r4_vld;
    bmfe_pkg::t_kind    r4_kind;
    logic [24:0]        r4_u2;
    logic [32:0]        r4_u4;
    logic [16:0]        r4_s;
    logic signed [24:0] r4_h1;
    logic [19:0]        r4_dm;

    logic [57:0]        w_u6p;
    logic [23:0]        w_h1m;
    logic               r5_vld;
    bmfe_pkg::t_kind    r5_kind;
    logic [41:0]        r5_u6;
    logic [33:0]        r5_ss;
    logic [43:0]        r5_p2;
    logic               r5_h1neg;
    logic [19:0]        r5_dm;

    logic [28:0]        w_r2;
    logic signed [29:0] w_r2s;
    logic               r6_vld;
    bmfe_pkg::t_kind    r6_kind;
    logic [41:0]        r6_den1;
    logic [17:0]        r6_a;
    logic signed [29:0] r6_h2;
    logic [19:0]        r6_dm;

    logic [AW-1:0]      w_ap;
    logic [AW-1:0]      w_ai;
    logic [28:0]        w_h2m;
    logic               r7_vld;
    bmfe_pkg::t_kind    r7_kind;
    logic [41:0]        r7_den1;
    logic [IW-1:0]      r7_idx;
    logic [48:0]        r7_p3;
    logic               r7_h2neg;

    logic [33:0]        w_r3;
    logic signed [35:0] w_r3s;
    logic               r8_vld;
    bmfe_pkg::t_kind    r8_kind;
    logic [41:0]        r8_den1;
    logic [bmfe_pkg::ENT_W-1:0] r8_ent;
    logic signed [35:0] r8_h3;

    logic [bmfe_pkg::MUL_W-1:0] w_mult;
    logic [bmfe_pkg::MUL_W-1:0] w_h3m;
    logic [bmfe_pkg::DEN_W-1:0] w_den;
    logic [23:0]        w_pm;
    logic               w_neg;
    logic               r9_vld;
    bmfe_pkg::t_kind    r9_kind;
    logic [51:0]        r9_prod;
    logic [bmfe_pkg::DEN_W-1:0] r9_den;
    logic               r9_neg;

    bmfe_pkg::t_quot    r_out;

    // Bell square, Gaussian offset scale, first cubic product.
    assign w_qq = 48'(i_dist.q) * 48'(i_dist.q);
    assign w_e  = (i_dist.dm >= bmfe_pkg::GAUSS_MU) ? (i_dist.dm - bmfe_pkg::GAUSS_MU)
                                                    : (bmfe_pkg::GAUSS_MU - i_dist.dm);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= i_dist.vld;
        end
        r3_kind <= i_dist.kind;
        r3_u2   <= (w_qq[47:16] > 32'h0100_0000) ? 25'h100_0000 : w_qq[40:16];
        r3_es   <= 40'(w_e) * 40'(bmfe_pkg::GAUSS_K);
        r3_t1p  <= 39'(i_dist.dm[19:0]) * 39'(bmfe_pkg::CUBIC_C3);
        r3_dm   <= i_dist.dm[19:0];
    end

    assign w_u2sq = 50'(r3_u2) * 50'(r3_u2);
    assign w_es   = 41'(r3_es) + 41'd32768;
    assign w_t1   = 24'((40'(r3_t1p) + 40'd32768) >> 16);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else begin
            r4_vld <= r3_vld;
        end
        r4_kind <= r3_kind;
        r4_u2   <= r3_u2;
        r4_u4   <= w_u2sq[48:16];
        r4_s    <= w_es[32:16];
        r4_h1   <= bmfe_pkg::CUBIC_C2 - $signed({1'b0, w_t1});
        r4_dm   <= r3_dm;
    end

    assign w_u6p = 58'(r4_u4) * 58'(r4_u2);
    assign w_h1m = r4_h1[24] ? 24'(-r4_h1) : 24'(r4_h1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else begin
            r5_vld <= r4_vld;
        end
        r5_kind  <= r4_kind;
        r5_u6    <= w_u6p[57:16];
        r5_ss    <= 34'(r4_s) * 34'(r4_s);
        r5_p2    <= 44'(w_h1m) * 44'(r4_dm);
        r5_h1neg <= r4_h1[24];
        r5_dm    <= r4_dm;
    end

    assign w_r2  = 29'((45'(r5_p2) + 45'd32768) >> 16);
    assign w_r2s = r5_h1neg ? -$signed({1'b0, w_r2}) : $signed({1'b0, w_r2});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else begin
            r6_vld <= r5_vld;
        end
        r6_kind <= r5_kind;
        r6_den1 <= r5_u6 + bmfe_pkg::UNIT_Q16;
        r6_a    <= 18'((35'(r5_ss) + 35'd65536) >> 17);
        r6_h2   <= w_r2s - bmfe_pkg::CUBIC_C1;
        r6_dm   <= r5_dm;
    end

    assign w_ap  = AW'(r6_a) * AW'(EXP_TABLE_DEPTH) + AW'(65536);
    assign w_ai  = w_ap >> 17;
    assign w_h2m = r6_h2[29] ? 29'(-r6_h2) : 29'(r6_h2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_vld <= 1'b0;
        end else begin
            r7_vld <= r6_vld;
        end
        r7_kind  <= r6_kind;
        r7_den1  <= r6_den1;
        r7_idx   <= (w_ai > AW'(EXP_TABLE_DEPTH - 1)) ? IW'(EXP_TABLE_DEPTH - 1) : IW'(w_ai);
        r7_p3    <= 49'(w_h2m) * 49'(r6_dm);
        r7_h2neg <= r6_h2[29];
    end

    assign w_r3  = 34'((50'(r7_p3) + 50'd32768) >> 16);
    assign w_r3s = r7_h2neg ? -$signed({2'b00, w_r3}) : $signed({2'b00, w_r3});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_vld <= 1'b0;
        end else begin
            r8_vld <= r7_vld;
        end
        r8_kind <= r7_kind;
        r8_den1 <= r7_den1;
        r8_ent  <= w_tab[r7_idx];
        r8_h3   <= w_r3s + bmfe_pkg::CUBIC_C0;
    end

    always_comb begin
        w_pm  = i_cfg.peak[23] ? 24'(-i_cfg.peak) : 24'(i_cfg.peak);
        w_h3m = r8_h3[35] ? bmfe_pkg::MUL_W'(-r8_h3) : bmfe_pkg::MUL_W'(r8_h3);
        w_neg = i_cfg.peak[23];
        case (r8_kind)
            bmfe_pkg::KIND_BELL: begin
                w_mult = bmfe_pkg::MUL_W'(65536);
                w_den  = r8_den1;
            end
            bmfe_pkg::KIND_GAUSS: begin
                w_mult = bmfe_pkg::MUL_W'(r8_ent);
                w_den  = bmfe_pkg::UNIT_Q16;
            end
            bmfe_pkg::KIND_CUBIC: begin
                w_mult = w_h3m;
                w_den  = bmfe_pkg::NORM_Q30;
                w_neg  = i_cfg.peak[23] ^ r8_h3[35];
            end
            default: begin
                w_mult = '0;
                w_den  = bmfe_pkg::UNIT_Q16;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r9_vld <= 1'b0;
        end else begin
            r9_vld <= r8_vld;
        end
        r9_kind <= r8_kind;
        r9_prod <= 52'(w_pm) * 52'(w_mult);
        r9_den  <= w_den;
        r9_neg  <= w_neg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.vld <= 1'b0;
        end else begin
            r_out.vld <= r9_vld;
        end
        r_out.kind <= r9_kind;
        r_out.num  <= bmfe_pkg::NUM_W'(r9_prod) + bmfe_pkg::NUM_W'(r9_den >> 1);
        r_out.den  <= r9_den;
        r_out.neg  <= r9_neg;
    end

    assign o_quot = r_out;

endmodule

// ----- hw/rtl/bmfe_div.sv -----
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on bmfe_pkg for widths and the item structs.
`timescale 1ns / 1ps

module bmfe_div (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bmfe_pkg::t_quot i_quot,
    output bmfe_pkg::t_dres o_dres
);

    localparam int NW = bmfe_pkg::NUM_W;
    localparam int DW = bmfe_pkg::DEN_W;
    localparam int QW = bmfe_pkg::QUO_W;
    localparam int CW = DW + QW;

    logic            r_vld  [QW];
    bmfe_pkg::t_kind r_kind [QW];
    logic [NW-1:0]   r_rem  [QW];
    logic [DW-1:0]   r_den  [QW];
    logic [QW-1:0]   r_quo  [QW];
    logic            r_neg  [QW];

    for (genvar g = 0; g < QW; g++) begin : g_stage
        localparam int B = QW - 1 - g;
        logic            w_vld;
        bmfe_pkg::t_kind w_kind;
        logic [NW-1:0]   w_rem;
        logic [DW-1:0]   w_den;
        logic [QW-1:0]   w_quo;
        logic            w_neg;
        logic [CW-1:0]   w_sh;
        logic            w_ge;

        if (g == 0) begin : g_first
            assign w_vld  = i_quot.vld;
            assign w_kind = i_quot.kind;
            assign w_rem  = i_quot.num;
            assign w_den  = i_quot.den;
            assign w_quo  = '0;
            assign w_neg  = i_quot.neg;
        end else begin : g_next
            assign w_vld  = r_vld[g-1];
            assign w_kind = r_kind[g-1];
            assign w_rem  = r_rem[g-1];
            assign w_den  = r_den[g-1];
            assign w_quo  = r_quo[g-1];
            assign w_neg  = r_neg[g-1];
        end

        assign w_sh = CW'(w_den) << B;
        assign w_ge = CW'(w_rem) >= w_sh;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else begin
                r_vld[g] <= w_vld;
            end
            r_kind[g] <= w_kind;
            r_rem[g]  <= w_ge ? NW'(CW'(w_rem) - w_sh) : w_rem;
            r_den[g]  <= w_den;
            r_quo[g]  <= w_quo | (QW'(w_ge) << B);
            r_neg[g]  <= w_neg;
        end
    end

    assign o_dres.vld  = r_vld[QW-1];
    assign o_dres.kind = r_kind[QW-1];
    assign o_dres.quo  = r_quo[QW-1];
    assign o_dres.neg  = r_neg[QW-1];

endmodule

// ----- hw/rtl/bell_magnet_field_evaluator_core.sv -----
// Top level of the bell magnet field evaluator: configuration registers,
// output saturation and routing. Uses bmfe_pkg, bmfe_dist, bmfe_shape, bmfe_div.
//
// Channel   Direction  Handshake                    Payload
// command   in         i_start, o_busy             i_pos_x, i_pos_y, i_pos_z
// result    out        o_result_valid (strobe)     o_field_x, o_field_y
// config    in         i_cfg_valid, o_cfg_ready    i_cfg_index, i_cfg_data
//
// One item is taken every clock cycle while o_busy is low; each result passes
// through the 12 arithmetic stages and the 25 stage divider that produces
// one quotient bit per stage.
// o_busy is high only in reset and until r_run is registered high after it.
// The result strobe lasts one cycle and cannot be held off.
`timescale 1ns / 1ps

module bell_magnet_field_evaluator_core #(
    parameter int EXP_TABLE_DEPTH = 256
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    output logic                                  o_busy,
    input  logic signed [bmfe_pkg::POS_W-1:0]     i_pos_x,
    input  logic signed [bmfe_pkg::POS_W-1:0]     i_pos_y,
    input  logic signed [bmfe_pkg::POS_W-1:0]     i_pos_z,
    output logic                                  o_result_valid,
    output logic signed [bmfe_pkg::FIELD_W-1:0]   o_field_x,
    output logic signed [bmfe_pkg::FIELD_W-1:0]   o_field_y,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [1:0]                            i_cfg_index,
    input  logic [bmfe_pkg::CFGD_W-1:0]           i_cfg_data
);

    logic             r_run;
    bmfe_pkg::t_cfg   r_cfg;
    bmfe_pkg::t_dist  w_dist;
    bmfe_pkg::t_quot  w_quot;
    bmfe_pkg::t_dres  w_dres;
    logic [23:0]      w_val;
    logic             r_valid;
    bmfe_pkg::t_kind  r_okind;
    logic [23:0]      r_fx;
    logic [23:0]      r_fy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
        end else begin
            r_run <= 1'b1;
        end
    end

    assign o_busy      = !r_run;
    assign o_cfg_ready = r_run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (bmfe_pkg::t_cfg_idx'(i_cfg_index))
                bmfe_pkg::CFG_PEAK:   r_cfg.peak   <= $signed(i_cfg_data);
                bmfe_pkg::CFG_MIDDLE: r_cfg.middle <= $signed(i_cfg_data[22:0]);
                bmfe_pkg::CFG_MODE:   r_cfg.mode   <= i_cfg_data[1:0];
                bmfe_pkg::CFG_TUBE:   r_cfg.tube   <= i_cfg_data[21:0];
                default: ;
            endcase
        end
    end

    bmfe_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (i_start && !o_busy),
        .i_pos_x (i_pos_x),
        .i_pos_y (i_pos_y),
        .i_pos_z (i_pos_z),
        .i_cfg   (r_cfg),
        .o_dist  (w_dist)
    );

    bmfe_shape #(
        .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
    ) u_shape (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_dist  (w_dist),
        .i_cfg   (r_cfg),
        .o_quot  (w_quot)
    );

    bmfe_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_quot  (w_quot),
        .o_dres  (w_dres)
    );

    always_comb begin
        if (w_dres.neg) begin
            w_val = (w_dres.quo > 25'd8388608) ? 24'h80_0000 : 24'(25'd0 - w_dres.quo);
        end else begin
            w_val = (w_dres.quo > 25'd8388607) ? 24'h7F_FFFF : 24'(w_dres.quo);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_dres.vld;
        end
        r_okind <= w_dres.kind;
        r_fx    <= (w_dres.kind == bmfe_pkg::KIND_GAUSS
                    || w_dres.kind == bmfe_pkg::KIND_CUBIC) ? w_val : 24'd0;
        r_fy    <= (w_dres.kind == bmfe_pkg::KIND_BELL) ? w_val : 24'd0;
    end

    assign o_result_valid = r_valid;
    assign o_field_x      = $signed(r_fx);
    assign o_field_y      = $signed(r_fy);

    a_busy_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_busy |-> !o_result_valid)
        else $error("result strobe while the block is still busy");

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && r_okind == bmfe_pkg::KIND_NONE
        |-> o_field_x == 0 && o_field_y == 0)
        else $error("nonzero field for an item outside every profile");

    a_bell_x_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && r_okind == bmfe_pkg::KIND_BELL |-> o_field_x == 0)
        else $error("bell profile produced an x field");

    a_fit_y_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && (r_okind == bmfe_pkg::KIND_GAUSS || r_okind == bmfe_pkg::KIND_CUBIC)
        |-> o_field_y == 0)
        else $error("fitted profile produced a y field");

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for the bell magnet field evaluator core.
// Drives field evaluations and register writes, predicts each field pair and compares.
// Depends on bmfe_pkg and bell_magnet_field_evaluator_core.
`timescale 1ns / 1ps

class field_scoreboard;
    logic signed [23:0] exp_bx[$];
    logic signed [23:0] exp_by[$];
    int                 errors;

    function void note_item(logic signed [23:0] bx, logic signed [23:0] by);
        exp_bx.push_back(bx);
        exp_by.push_back(by);
    endfunction

    function void check_result(logic signed [23:0] bx, logic signed [23:0] by);
        logic signed [23:0] eb;
        logic signed [23:0] ey;
        if (exp_bx.size() == 0) begin
            $display("%0t: unexpected result bx=%0d by=%0d", $time, bx, by);
            errors++;
            return;
        end
        eb = exp_bx.pop_front();
        ey = exp_by.pop_front();
        if (bx !== eb) begin
            $display("%0t: field_x expected %0d actual %0d", $time, eb, bx);
            errors++;
        end
        if (by !== ey) begin
            $display("%0t: field_y expected %0d actual %0d", $time, ey, by);
            errors++;
        end
    endfunction

    function int pending();
        return exp_bx.size();
    endfunction
endclass

module testbench;

    localparam int DEPTH = 256;
    localparam int WATCH_LIMIT = 2000;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_start;
    logic              o_busy;
    logic signed [22:0] i_pos_x;
    logic signed [22:0] i_pos_y;
    logic signed [22:0] i_pos_z;
    logic              o_result_valid;
    logic signed [23:0] o_field_x;
    logic signed [23:0] o_field_y;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [1:0]        i_cfg_index;
    logic [23:0]       i_cfg_data;

    field_scoreboard sb;
    longint unsigned exp_rom[DEPTH];
    longint          cfg_peak;
    longint          cfg_mid;
    logic [1:0]      cfg_mode;
    longint          cfg_tube;
    int              idle_cycles;
    bit              quiet;

    bell_magnet_field_evaluator_core #(.EXP_TABLE_DEPTH(DEPTH)) DUT (.*);

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic longint unsigned magnitude(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint scale_round(longint a, longint b, longint unsigned dv);
        longint unsigned p;
        longint unsigned r;
        p = magnitude(a) * magnitude(b);
        r = (p + dv / 2) / dv;
        return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
    endfunction

    function automatic logic signed [23:0] clip24(longint v);
        if (v > 8388607) v = 8388607;
        if (v < -8388608) v = -8388608;
        return 24'(v);
    endfunction

    function automatic void fill_exp_rom();
        longint unsigned x;
        longint unsigned term;
        longint          sum;
        for (int i = 0; i < DEPTH; i++) begin
            x = (longint'(i) << 31) / DEPTH;
            term = 64'd1 << 30;
            sum = term;
            for (int k = 1; k <= 30; k++) begin
                term = ((term * x) >> 30) / k;
                if (k % 2) sum -= term;
                else sum += term;
            end
            if (sum < 0) sum = 0;
            exp_rom[i] = (sum + 8192) >> 14;
        end
    endfunction

    task automatic predict_field(input longint x, input longint y, input longint z);
        longint unsigned dz, q, u2, u4, u6, dm, e, s, a, idx;
        longint          h, bx, by;
        bit              in_box;
        dz = magnitude(z - cfg_mid);
        bx = 0;
        by = 0;
        if (cfg_mode == bmfe_pkg::MODE_BELL) begin
            q = (dz << 16) / 53760;
            u2 = (q * q) >> 16;
            if (u2 > (64'd1 << 24)) u2 = 64'd1 << 24;
            u4 = (u2 * u2) >> 16;
            u6 = (u4 * u2) >> 16;
            by = scale_round(cfg_peak, 65536, 65536 + u6);
        end else if (cfg_mode == bmfe_pkg::MODE_FIT) begin
            in_box = magnitude(x) < 69120 && magnitude(y) < cfg_tube + 5120;
            dm = (dz * 64) / 25;
            if (in_box && dz < 97280) begin
                e = magnitude(longint'(dm) - 2981);
                s = (e * 26166 + 32768) >> 16;
                a = (s * s + 65536) >> 17;
                idx = (a * DEPTH + 65536) >> 17;
                if (idx > DEPTH - 1) idx = DEPTH - 1;
                bx = scale_round(cfg_peak, exp_rom[idx], 65536);
            end else if (in_box && dz < 304640) begin
                h = 7349441 - scale_round(dm, 275651, 65536);
                h = scale_round(dm, h, 65536) - 66048007;
                h = scale_round(dm, h, 65536) + 209723253;
                bx = scale_round(cfg_peak, h, 154200063);
            end
        end
        sb.note_item(clip24(bx), clip24(by));
    endtask

    task automatic write_reg(input bmfe_pkg::t_cfg_idx idx, input longint val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= 24'(val);
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            bmfe_pkg::CFG_PEAK:   cfg_peak = longint'($signed(24'(val)));
            bmfe_pkg::CFG_MIDDLE: cfg_mid = longint'($signed(23'(val)));
            bmfe_pkg::CFG_MODE:   cfg_mode = val[1:0];
            bmfe_pkg::CFG_TUBE:   cfg_tube = {42'b0, val[21:0]};
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_start <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (45) @(posedge i_clk);
    endtask

    task automatic set_config(input longint pk, input longint md, input int mo,
                              input longint tb);
        drain();
        write_reg(bmfe_pkg::CFG_PEAK, pk);
        write_reg(bmfe_pkg::CFG_MIDDLE, md);
        write_reg(bmfe_pkg::CFG_MODE, mo);
        write_reg(bmfe_pkg::CFG_TUBE, tb);
    endtask

    task automatic send_point(input longint x, input longint y, input longint z);
        int gap;
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 17);
            i_start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_start <= 1'b1;
        i_pos_x <= 23'(x);
        i_pos_y <= 23'(y);
        i_pos_z <= 23'(z);
        do @(posedge i_clk); while (o_busy);
        predict_field(x, y, z);
    endtask

    function automatic longint rand_pos();
        case ($urandom_range(0, 3))
            0: return longint'($signed(23'($urandom)));
            1: return longint'($urandom_range(0, 140000)) - 70000;
            2: return longint'($urandom_range(0, 640000)) - 320000;
            default: return longint'($urandom_range(0, 20000)) - 10000;
        endcase
    endfunction

    function automatic longint rand_dz_z();
        case ($urandom_range(0, 2))
            0: return cfg_mid + longint'($urandom_range(0, 97280))
                       * (($urandom_range(0, 1) != 0) ? 1 : -1);
            1: return cfg_mid + longint'($urandom_range(97000, 305000))
                       * (($urandom_range(0, 1) != 0) ? 1 : -1);
            default: return rand_pos();
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) sb.check_result(o_field_x, o_field_y);
    end

    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_result_valid || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        longint z;
        sb = new();
        fill_exp_rom();
        idle_cycles = 0;
        quiet = 1'b0;
        cfg_peak = 0;
        cfg_mid = 0;
        cfg_mode = '0;
        cfg_tube = 0;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_pos_x = '0;
        i_pos_y = '0;
        i_pos_z = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = bmfe_pkg::CFG_PEAK;
        i_cfg_data = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_point(-4194304, 4194303, 1000);
        set_config(8388607, 0, bmfe_pkg::MODE_BELL, 0);
        send_point(0, 0, 0);
        send_point(0, 0, 53760);
        send_point(0, 0, -4194304);
        send_point(0, 0, 4194303);
        set_config(-8388608, -4194304, bmfe_pkg::MODE_BELL, 4194303);
        send_point(0, 0, 4194303);
        send_point(0, 0, -4194304);
        set_config(-8388608, 0, bmfe_pkg::MODE_FIT, 0);
        send_point(69119, 5119, 0);
        send_point(69120, 0, 0);
        send_point(-69119, -5119, 97279);
        send_point(0, -5120, 0);
        send_point(0, 0, 97280);
        send_point(0, 0, -304639);
        send_point(0, 0, 304640);
        send_point(0, 0, 7632);
        set_config(8388607, 4194303, bmfe_pkg::MODE_FIT, 4194303);
        send_point(-4194304, 4194303, 4194303);
        send_point(0, -4194304, 4194303 - 150000);
        set_config(8388607, 0, 3, 100);
        send_point(0, 0, 0);

        for (int ph = 0; ph < 9; ph++) begin
            set_config(longint'($signed(24'($urandom))),
                       longint'($urandom_range(0, 400000)) - 200000,
                       (ph % 3 == 2) ? $urandom_range(0, 3) : 1 + ph % 2,
                       ph == 4 ? 4194303 : $urandom_range(0, 30000));
            if (ph >= 7) quiet = 1'b1;
            for (int n = 0; n < 50; n++) begin
                z = rand_dz_z();
                if (z > 4194303) z = 4194303;
                if (z < -4194304) z = -4194304;
                send_point(rand_pos(), rand_pos(), z);
            end
        end
        @(negedge i_clk);
        i_start <= 1'b0;
        drain();
        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

// ----- bell_magnet_field_evaluator_core.f -----
hw/rtl/bmfe_pkg.sv
hw/rtl/bmfe_dist.sv
hw/rtl/bmfe_shape.sv
hw/rtl/bmfe_div.sv
hw/rtl/bell_magnet_field_evaluator_core.sv
test/testbench.sv
